// ----- hdl/duration_text_to_ms_top_macros.svh -----
// ----------------------------------------------------------------------------
// Duration text parser assertion macros
// Shared property forms for the assertions of the duration text parser.
// ----------------------------------------------------------------------------
`ifndef DURATION_TEXT_TO_MS_TOP_MACROS_SVH
`define DURATION_TEXT_TO_MS_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk and switched off during reset.
`define DTM_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and switched off during reset.
`define DTM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/dtm_pkg.sv -----
// ----------------------------------------------------------------------------
// Duration text parser package
// Types, character codes, unit multipliers and status codes of the parser.
// ----------------------------------------------------------------------------
package dtm_pkg;

    localparam int ACC_BITS_DEFAULT = 48;
    localparam int OUT_BITS         = 48;
    localparam int CHAR_W           = 8;
    localparam int DIGIT_W          = 4;
    localparam int MULT_W           = 22;
    localparam int QUEUE_DEPTH      = 4;

    localparam logic [CHAR_W-1:0] CH_0     = 8'h30;
    localparam logic [CHAR_W-1:0] CH_9     = 8'h39;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0d;
    localparam logic [CHAR_W-1:0] CH_M     = 8'h6d;
    localparam logic [CHAR_W-1:0] CH_S     = 8'h73;
    localparam logic [CHAR_W-1:0] CH_H     = 8'h68;

    localparam logic [MULT_W-1:0] MS_PER_MS  = MULT_W'(1);
    localparam logic [MULT_W-1:0] MS_PER_S   = MULT_W'(1000);
    localparam logic [MULT_W-1:0] MS_PER_MIN = MULT_W'(60000);
    localparam logic [MULT_W-1:0] MS_PER_H   = MULT_W'(3600000);

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_EMPTY   = 3'd1,
        ST_BADTOK  = 3'd2,
        ST_NOUNIT  = 3'd3,
        ST_BADUNIT = 3'd4,
        ST_NOTPOS  = 3'd5,
        ST_OVF     = 3'd6
    } status_t;

    typedef enum logic [2:0] {
        CL_DIGIT,
        CL_WS,
        CL_M,
        CL_S,
        CL_H,
        CL_OTHER
    } cls_t;

    typedef enum logic [1:0] {
        PH_BETWEEN,
        PH_NUMBER,
        PH_MPEND
    } phase_t;

    typedef enum logic [1:0] {
        U_MS,
        U_S,
        U_MIN,
        U_H
    } unit_t;

    typedef struct packed {
        cls_t               cls;
        logic [DIGIT_W-1:0] digit;
        logic               last;
        logic               no_char;
    } item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_stat_t;

    typedef struct packed {
        logic    add;
        unit_t   unit;
        status_t err;
        logic    last;
    } op_ctl_t;

    function automatic cls_t classify(input logic [CHAR_W-1:0] c);
        cls_t cls;
        if (c >= CH_0 && c <= CH_9)
            cls = CL_DIGIT;
        else if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR))
            cls = CL_WS;
        else if (c == CH_M)
            cls = CL_M;
        else if (c == CH_S)
            cls = CL_S;
        else if (c == CH_H)
            cls = CL_H;
        else
            cls = CL_OTHER;
        return cls;
    endfunction

    function automatic logic [MULT_W-1:0] unit_mult(input unit_t u);
        logic [MULT_W-1:0] k;
        unique case (u)
            U_MS:  k = MS_PER_MS;
            U_S:   k = MS_PER_S;
            U_MIN: k = MS_PER_MIN;
            U_H:   k = MS_PER_H;
        endcase
        return k;
    endfunction

endpackage

// ----- hdl/dtm_if.sv -----
// ----------------------------------------------------------------------------
// Duration text parser channels
// Valid/ready channels for the character stream and the result stream.
// ----------------------------------------------------------------------------
interface dtm_char_if;
    logic                        valid;
    logic                        ready;
    logic [dtm_pkg::CHAR_W-1:0]  char_code;
    logic                        last;
    logic                        no_char;

    modport source (output valid, output char_code, output last, output no_char, input ready);
    modport sink (input valid, input char_code, input last, input no_char, output ready);
endinterface

interface dtm_result_if;
    logic                          valid;
    logic                          ready;
    logic [dtm_pkg::OUT_BITS-1:0]  total_ms;
    logic [2:0]                    status;

    modport source (output valid, output total_ms, output status, input ready);
    modport sink (input valid, input total_ms, input status, output ready);
endinterface

// ----- hdl/dtm_front.sv -----
// ----------------------------------------------------------------------------
// Duration text parser front end
// Accepts character beats and classifies each character for the queue.
// ----------------------------------------------------------------------------
module dtm_front
(
    dtm_char_if.sink               chars,
    input  dtm_pkg::queue_stat_t   stat,
    output dtm_pkg::item_t         item,
    output logic                   push
);

    assign chars.ready = !stat.full;
    assign push        = chars.valid && !stat.full;

    always_comb
    begin
        item.cls     = dtm_pkg::classify(chars.char_code);
        item.digit   = chars.char_code[dtm_pkg::DIGIT_W-1:0];
        item.last    = chars.last;
        item.no_char = chars.no_char;
    end

endmodule

// ----- hdl/dtm_queue.sv -----
// ----------------------------------------------------------------------------
// Duration text parser queue
// Short queue of classified characters between the front and back ends.
// ----------------------------------------------------------------------------
module dtm_queue
#(
    parameter int DEPTH = dtm_pkg::QUEUE_DEPTH
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  dtm_pkg::item_t        wr_item,
    input  logic                  push,
    input  logic                  pop,
    output dtm_pkg::item_t        rd_item,
    output dtm_pkg::queue_stat_t  stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    dtm_pkg::item_t    entry_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;

    assign rd_item    = entry_reg[rd_ptr_reg];
    assign stat.full  = (count_reg == CNT_W'(DEPTH));
    assign stat.empty = (count_reg == '0);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        unique case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= wr_item;
        end
    end

endmodule

// ----- hdl/dtm_parse.sv -----
// ----------------------------------------------------------------------------
// Duration text parser term decoder
// Walks the term grammar one character per cycle while its operation register is free and issues term operations.
// ----------------------------------------------------------------------------
module dtm_parse
#(
    parameter int ACC_BITS = dtm_pkg::ACC_BITS_DEFAULT
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  dtm_pkg::item_t         item,
    input  dtm_pkg::queue_stat_t   stat,
    output logic                   pop,
    output logic                   op_valid,
    output dtm_pkg::op_ctl_t       op_ctl,
    output logic [ACC_BITS-1:0]    op_value,
    input  logic                   op_take
);

    localparam int NW = ACC_BITS + 4;

    dtm_pkg::phase_t      phase_reg;
    dtm_pkg::phase_t      phase_next;
    logic [ACC_BITS-1:0]  number_reg;
    logic [ACC_BITS-1:0]  number_next;
    logic                 err_reg;
    logic                 err_next;
    logic                 seen_reg;
    logic                 seen_next;
    logic                 op_valid_reg;
    dtm_pkg::op_ctl_t     op_ctl_reg;
    dtm_pkg::op_ctl_t     op_ctl_next;
    logic [ACC_BITS-1:0]  op_value_reg;
    logic [NW-1:0]        dig_sum;
    logic                 dig_ovf;

    assign pop      = !stat.empty && (!op_valid_reg || op_take);
    assign op_valid = op_valid_reg;
    assign op_ctl   = op_ctl_reg;
    assign op_value = op_value_reg;

    assign dig_sum = (NW'(number_reg) << 3) + (NW'(number_reg) << 1) + NW'(item.digit);
    assign dig_ovf = |dig_sum[NW-1:ACC_BITS];

    always_comb
    begin
        phase_next       = phase_reg;
        number_next      = number_reg;
        err_next         = err_reg;
        seen_next        = seen_reg;
        op_ctl_next.add  = 1'b0;
        op_ctl_next.unit = dtm_pkg::U_MS;
        op_ctl_next.err  = dtm_pkg::ST_OK;
        op_ctl_next.last = item.last;

        if (!item.no_char)
        begin
            seen_next = 1'b1;
            if (!err_reg)
            begin
                unique case (phase_reg)
                    dtm_pkg::PH_NUMBER:
                    begin
                        unique case (item.cls)
                            dtm_pkg::CL_DIGIT:
                            begin
                                if (dig_ovf)
                                begin
                                    op_ctl_next.err = dtm_pkg::ST_OVF;
                                    err_next        = 1'b1;
                                end
                                else
                                begin
                                    number_next = dig_sum[ACC_BITS-1:0];
                                end
                            end
                            dtm_pkg::CL_M:
                            begin
                                phase_next = dtm_pkg::PH_MPEND;
                            end
                            dtm_pkg::CL_S:
                            begin
                                op_ctl_next.add  = 1'b1;
                                op_ctl_next.unit = dtm_pkg::U_S;
                                phase_next       = dtm_pkg::PH_BETWEEN;
                            end
                            dtm_pkg::CL_H:
                            begin
                                op_ctl_next.add  = 1'b1;
                                op_ctl_next.unit = dtm_pkg::U_H;
                                phase_next       = dtm_pkg::PH_BETWEEN;
                            end
                            default:
                            begin
                                op_ctl_next.err = dtm_pkg::ST_BADUNIT;
                                err_next        = 1'b1;
                            end
                        endcase
                    end
                    dtm_pkg::PH_MPEND:
                    begin
                        // The pending m closes as minutes unless s follows; the
                        // character after the minutes then opens the next term.
                        phase_next      = dtm_pkg::PH_BETWEEN;
                        op_ctl_next.add = 1'b1;
                        if (item.cls == dtm_pkg::CL_S)
                        begin
                            op_ctl_next.unit = dtm_pkg::U_MS;
                        end
                        else
                        begin
                            op_ctl_next.unit = dtm_pkg::U_MIN;
                            if (item.cls == dtm_pkg::CL_DIGIT)
                            begin
                                number_next = ACC_BITS'(item.digit);
                                phase_next  = dtm_pkg::PH_NUMBER;
                            end
                            else if (item.cls != dtm_pkg::CL_WS)
                            begin
                                op_ctl_next.err = dtm_pkg::ST_BADTOK;
                                err_next        = 1'b1;
                            end
                        end
                    end
                    default:
                    begin
                        if (item.cls == dtm_pkg::CL_DIGIT)
                        begin
                            number_next = ACC_BITS'(item.digit);
                            phase_next  = dtm_pkg::PH_NUMBER;
                        end
                        else if (item.cls != dtm_pkg::CL_WS)
                        begin
                            op_ctl_next.err = dtm_pkg::ST_BADTOK;
                            err_next        = 1'b1;
                        end
                    end
                endcase
            end
        end

        if (item.last)
        begin
            if (!seen_next)
            begin
                op_ctl_next.err = dtm_pkg::ST_EMPTY;
            end
            else if (!err_next && phase_next == dtm_pkg::PH_NUMBER)
            begin
                op_ctl_next.err = dtm_pkg::ST_NOUNIT;
            end
            else if (!err_next && phase_next == dtm_pkg::PH_MPEND)
            begin
                op_ctl_next.add  = 1'b1;
                op_ctl_next.unit = dtm_pkg::U_MIN;
            end
            phase_next  = dtm_pkg::PH_BETWEEN;
            number_next = '0;
            err_next    = 1'b0;
            seen_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= dtm_pkg::PH_BETWEEN;
            number_reg   <= '0;
            err_reg      <= 1'b0;
            seen_reg     <= 1'b0;
            op_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                phase_reg    <= phase_next;
                number_reg   <= number_next;
                err_reg      <= err_next;
                seen_reg     <= seen_next;
                op_valid_reg <= 1'b1;
            end
            else if (op_take)
            begin
                op_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            op_ctl_reg   <= op_ctl_next;
            op_value_reg <= number_reg;
        end
    end

endmodule

// ----- hdl/dtm_accum.sv -----
// ----------------------------------------------------------------------------
// Duration text parser accumulator
// Scales each term to milliseconds, sums the terms and holds the result beat.
// ----------------------------------------------------------------------------
module dtm_accum
#(
    parameter int ACC_BITS = dtm_pkg::ACC_BITS_DEFAULT
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   op_valid,
    input  dtm_pkg::op_ctl_t       op_ctl,
    input  logic [ACC_BITS-1:0]    op_value,
    output logic                   op_take,
    dtm_result_if.source           result
);

    localparam int PW = ACC_BITS + dtm_pkg::MULT_W;
    localparam int WW = (ACC_BITS > dtm_pkg::OUT_BITS) ? ACC_BITS : dtm_pkg::OUT_BITS;

    logic [PW-1:0]                   prod_full;
    logic                            p_valid_reg;
    dtm_pkg::op_ctl_t                p_ctl_reg;
    logic [ACC_BITS-1:0]             prod_reg;
    logic                            povf_reg;
    logic                            p_consume;
    logic [ACC_BITS:0]               sum;
    logic [ACC_BITS-1:0]             total_reg;
    logic [ACC_BITS-1:0]             total_next;
    dtm_pkg::status_t                sticky_reg;
    dtm_pkg::status_t                sticky_next;
    dtm_pkg::status_t                final_status;
    logic [WW-1:0]                   total_wide;
    logic                            out_valid_reg;
    logic [dtm_pkg::OUT_BITS-1:0]    out_total_reg;
    dtm_pkg::status_t                out_status_reg;

    assign p_consume = p_valid_reg && (!p_ctl_reg.last || !out_valid_reg || result.ready);
    assign op_take   = !p_valid_reg || p_consume;

    assign prod_full = PW'(op_value) * PW'(dtm_pkg::unit_mult(op_ctl.unit));

    assign sum = {1'b0, total_reg} + {1'b0, prod_reg};

    always_comb
    begin
        total_next  = total_reg;
        sticky_next = sticky_reg;
        if (sticky_reg == dtm_pkg::ST_OK)
        begin
            if (p_ctl_reg.add)
            begin
                if (povf_reg || sum[ACC_BITS])
                    sticky_next = dtm_pkg::ST_OVF;
                else
                    total_next = sum[ACC_BITS-1:0];
            end
            if (sticky_next == dtm_pkg::ST_OK && p_ctl_reg.err != dtm_pkg::ST_OK)
            begin
                sticky_next = p_ctl_reg.err;
            end
        end
        priority if (sticky_next != dtm_pkg::ST_OK)
            final_status = sticky_next;
        else if (total_next == '0)
            final_status = dtm_pkg::ST_NOTPOS;
        else
            final_status = dtm_pkg::ST_OK;
        total_wide = WW'(total_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg   <= 1'b0;
            total_reg     <= '0;
            sticky_reg    <= dtm_pkg::ST_OK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (op_take)
            begin
                p_valid_reg <= op_valid;
            end
            if (p_consume && p_ctl_reg.last)
            begin
                total_reg     <= '0;
                sticky_reg    <= dtm_pkg::ST_OK;
                out_valid_reg <= 1'b1;
            end
            else
            begin
                if (p_consume)
                begin
                    total_reg  <= total_next;
                    sticky_reg <= sticky_next;
                end
                if (result.ready)
                begin
                    out_valid_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (op_take && op_valid)
        begin
            p_ctl_reg <= op_ctl;
            prod_reg  <= prod_full[ACC_BITS-1:0];
            povf_reg  <= |prod_full[PW-1:ACC_BITS];
        end
        if (p_consume && p_ctl_reg.last)
        begin
            out_status_reg <= final_status;
            out_total_reg  <= (final_status == dtm_pkg::ST_OK) ?
                              total_wide[dtm_pkg::OUT_BITS-1:0] : '0;
        end
    end

    assign result.valid    = out_valid_reg;
    assign result.total_ms = out_total_reg;
    assign result.status   = out_status_reg;

endmodule

// ----- hdl/duration_text_to_ms_top.sv -----
// ----------------------------------------------------------------------------
// Duration text to milliseconds
// Parses a duration string such as "1h 30m 250ms" into a millisecond total.
// ----------------------------------------------------------------------------
// The block takes one character beat per clock while its queue has room, and
// returns one result beat for each beat marked last, registered through the
// queue, operation, multiplier and result registers; the rate is set by the
// term decoder, which updates its state once per character, and by the
// accumulator, which adds one scaled term per cycle unless a result waits.

`include "duration_text_to_ms_top_macros.svh"

module duration_text_to_ms_top
#(
    parameter int ACC_BITS    = dtm_pkg::ACC_BITS_DEFAULT,
    parameter int QUEUE_DEPTH = dtm_pkg::QUEUE_DEPTH
)
(
    input  logic          clk,
    input  logic          rst_n,
    dtm_char_if.sink      chars,
    dtm_result_if.source  result
);

    dtm_pkg::item_t        q_wr_item;
    dtm_pkg::item_t        q_rd_item;
    dtm_pkg::queue_stat_t  q_stat;
    logic                  q_push;
    logic                  q_pop;
    logic                  op_valid;
    dtm_pkg::op_ctl_t      op_ctl;
    logic [ACC_BITS-1:0]   op_value;
    logic                  op_take;

    dtm_front u_front
    (
        .chars (chars),
        .stat  (q_stat),
        .item  (q_wr_item),
        .push  (q_push)
    );

    dtm_queue
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_item (q_wr_item),
        .push    (q_push),
        .pop     (q_pop),
        .rd_item (q_rd_item),
        .stat    (q_stat)
    );

    dtm_parse
    #(
        .ACC_BITS (ACC_BITS)
    )
    u_parse
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .item     (q_rd_item),
        .stat     (q_stat),
        .pop      (q_pop),
        .op_valid (op_valid),
        .op_ctl   (op_ctl),
        .op_value (op_value),
        .op_take  (op_take)
    );

    dtm_accum
    #(
        .ACC_BITS (ACC_BITS)
    )
    u_accum
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .op_valid (op_valid),
        .op_ctl   (op_ctl),
        .op_value (op_value),
        .op_take  (op_take),
        .result   (result)
    );

    `DTM_ASSERT_IMPLY(a_push_room, q_push, !q_stat.full, "character beat written into a full queue")
    `DTM_ASSERT_IMPLY(a_pop_data, q_pop, !q_stat.empty, "term decoder read from an empty queue")
    `DTM_ASSERT_NEXT(a_pop_load, q_pop, op_valid, "decoded character did not reach the operation register")
    `DTM_ASSERT_IMPLY(a_err_zero, result.valid && result.status != dtm_pkg::ST_OK, result.total_ms == '0, "failed result carries a non-zero total")

endmodule
